// ===== rtl/swms_pkg.sv =====
// ----------------------------------------------------------------------------
// swms_pkg
// Shared constants and types for the sliding window majority smoother.
// ----------------------------------------------------------------------------
package swms_pkg;

  localparam int WINDOW     = 16;
  localparam int NUM_ZONES  = 8;

  localparam int ZONE_W     = 4;
  localparam int THR_W      = 5;
  localparam int CNT_W      = $clog2(WINDOW + 1);
  localparam int SLOT_W     = $clog2(WINDOW);
  localparam int CNT_DEPTH  = NUM_ZONES + 1;
  localparam int CNT_AW     = $clog2(CNT_DEPTH);
  localparam int CMP_W      = (CNT_W > THR_W) ? CNT_W : THR_W;

  localparam int OQ_DEPTH   = 3;
  localparam int OQ_AW      = $clog2(OQ_DEPTH);
  localparam int OQ_CW      = $clog2(OQ_DEPTH + 1);

  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  typedef logic [ZONE_W-1:0] zone_t;
  typedef logic [THR_W-1:0]  thr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [CNT_AW-1:0] caddr_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CMP_W-1:0]  cmp_t;

  // register word index (paddr[2])
  localparam logic REG_SWITCH_THRESHOLD = 1'b0;

  localparam zone_t RESET_ZONE = zone_t'(3);
  localparam thr_t  THR_RESET  = thr_t'(8);

  // result leaving the count stage
  typedef struct packed {
    logic  valid;
    zone_t smoothed_zone;
    logic  switched;
  } res_t;

endpackage

// ===== rtl/swms_ram.sv =====
// ----------------------------------------------------------------------------
// swms_ram
// Generic RAM: two write ports, two registered read ports, read-first.
// ----------------------------------------------------------------------------
module swms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we_a,
  input  logic [$clog2(DEPTH)-1:0] waddr_a,
  input  logic [WIDTH-1:0]         wdata_a,
  input  logic                     we_b,
  input  logic [$clog2(DEPTH)-1:0] waddr_b,
  input  logic [WIDTH-1:0]         wdata_b,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
    if (we_a) begin
      mem[waddr_a] <= wdata_a;
    end
    if (we_b) begin
      mem[waddr_b] <= wdata_b;
    end
  end

endmodule

// ===== rtl/swms_ring.sv =====
// ----------------------------------------------------------------------------
// swms_ring
// History ring of recent zones. The entry at the write slot is prefetched
// so the zone about to be overwritten is ready when an item arrives.
// ----------------------------------------------------------------------------
module swms_ring import swms_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  take,
  input  logic  zone_ok,
  input  zone_t zone,
  output zone_t old_zone
);

  slot_t             write_slot;
  slot_t             write_slot_next;
  slot_t             raddr;
  logic [WINDOW-1:0] slot_valid;
  logic              rd_valid;
  zone_t             rd_zone;
  logic              we;

  assign we = take && zone_ok;

  always_comb begin
    write_slot_next = write_slot;
    if (we) begin
      write_slot_next = (write_slot == slot_t'(WINDOW - 1)) ? '0 : write_slot + slot_t'(1);
    end
  end

  // read the slot the next item will overwrite; never the slot written now
  assign raddr = rst ? '0 : write_slot_next;

  swms_ram #(
    .WIDTH (ZONE_W),
    .DEPTH (WINDOW)
  ) u_ring_ram (
    .clk     (clk),
    .we_a    (we),
    .waddr_a (write_slot),
    .wdata_a (zone),
    .we_b    (1'b0),
    .waddr_b ('0),
    .wdata_b ('0),
    .raddr_a (raddr),
    .rdata_a (rd_zone),
    .raddr_b (raddr),
    .rdata_b ()
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      slot_valid <= '0;
      rd_valid   <= 1'b0;
    end else begin
      write_slot <= write_slot_next;
      rd_valid   <= slot_valid[raddr];
      if (we) begin
        slot_valid[write_slot] <= 1'b1;
      end
    end
  end

  // never-written slots read as zero
  assign old_zone = rd_valid ? rd_zone : '0;

endmodule

// ===== rtl/swms_count.sv =====
// ----------------------------------------------------------------------------
// swms_count
// Zone occurrence counts: read at accept, update and write back in the next
// cycle, with forwarding of the previous item's writes. Holds the
// smoothed zone and forms the result.
// ----------------------------------------------------------------------------
module swms_count import swms_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  take,
  input  logic  zone_ok,
  input  zone_t zone,
  input  logic  confident,
  input  zone_t old_zone,
  input  thr_t  thr,
  output res_t  res
);

  caddr_t             raddr_a;
  caddr_t             raddr_b;
  cnt_t               rd_a;
  cnt_t               rd_b;
  logic [CNT_DEPTH-1:0] cnt_valid;
  logic               rv_a;
  logic               rv_b;

  logic               b_valid;
  logic               b_ok;
  logic               b_conf;
  zone_t              b_zone;
  caddr_t             b_oaddr;
  caddr_t             b_zaddr;

  logic               fw_we_a;
  caddr_t             fw_addr_a;
  cnt_t               fw_data_a;
  logic               fw_we_b;
  caddr_t             fw_addr_b;
  cnt_t               fw_data_b;

  zone_t              cur_zone;

  cnt_t               old_cnt;
  cnt_t               z_cnt;
  cnt_t               dec_cnt;
  cnt_t               z_base;
  cnt_t               z_new;
  logic               we_a;
  logic               we_b;
  logic               sw;

  assign raddr_a = old_zone[CNT_AW-1:0];
  assign raddr_b = zone[CNT_AW-1:0];
  assign b_zaddr = b_zone[CNT_AW-1:0];

  swms_ram #(
    .WIDTH (CNT_W),
    .DEPTH (CNT_DEPTH)
  ) u_cnt_ram (
    .clk     (clk),
    .we_a    (we_a),
    .waddr_a (b_oaddr),
    .wdata_a (dec_cnt),
    .we_b    (we_b),
    .waddr_b (b_zaddr),
    .wdata_b (z_new),
    .raddr_a (raddr_a),
    .rdata_a (rd_a),
    .raddr_b (raddr_b),
    .rdata_b (rd_b)
  );

  always_comb begin
    // newest write wins: port b carries the new zone's count
    priority if (fw_we_b && fw_addr_b == b_oaddr) begin
      old_cnt = fw_data_b;
    end else if (fw_we_a && fw_addr_a == b_oaddr) begin
      old_cnt = fw_data_a;
    end else begin
      old_cnt = rv_a ? rd_a : '0;
    end

    priority if (fw_we_b && fw_addr_b == b_zaddr) begin
      z_cnt = fw_data_b;
    end else if (fw_we_a && fw_addr_a == b_zaddr) begin
      z_cnt = fw_data_a;
    end else begin
      z_cnt = rv_b ? rd_b : '0;
    end

    dec_cnt = (old_cnt != '0) ? old_cnt - cnt_t'(1) : old_cnt;
    z_base  = (b_oaddr == b_zaddr) ? dec_cnt : z_cnt;
    z_new   = (z_base < cnt_t'(WINDOW)) ? z_base + cnt_t'(1) : z_base;

    we_b = b_valid && b_ok;
    we_a = we_b && (b_oaddr != b_zaddr);

    sw = we_b && b_conf && (cmp_t'(z_new) > cmp_t'(thr)) && (b_zone != cur_zone);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      rv_a      <= 1'b0;
      rv_b      <= 1'b0;
      cnt_valid <= '0;
      fw_we_a   <= 1'b0;
      fw_we_b   <= 1'b0;
      cur_zone  <= RESET_ZONE;
    end else begin
      b_valid <= take;
      rv_a    <= cnt_valid[raddr_a];
      rv_b    <= cnt_valid[raddr_b];
      fw_we_a <= we_a;
      fw_we_b <= we_b;
      if (we_a) begin
        cnt_valid[b_oaddr] <= 1'b1;
      end
      if (we_b) begin
        cnt_valid[b_zaddr] <= 1'b1;
      end
      if (sw) begin
        cur_zone <= b_zone;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      b_ok    <= zone_ok;
      b_conf  <= confident;
      b_zone  <= zone;
      b_oaddr <= raddr_a;
    end
    fw_addr_a <= b_oaddr;
    fw_data_a <= dec_cnt;
    fw_addr_b <= b_zaddr;
    fw_data_b <= z_new;
  end

  assign res.valid         = b_valid;
  assign res.smoothed_zone = sw ? b_zone : cur_zone;
  assign res.switched      = sw;

endmodule

// ===== rtl/swms_outq.sv =====
// ----------------------------------------------------------------------------
// swms_outq
// Small result queue that decouples the count stage from output stalls.
// ----------------------------------------------------------------------------
module swms_outq import swms_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  res_t             res,
  output logic [OQ_CW-1:0] occ,
  output logic             out_valid,
  input  logic             out_ready,
  output zone_t            smoothed_zone,
  output logic             switched
);

  typedef struct packed {
    zone_t zone;
    logic  sw;
  } entry_t;

  typedef logic [OQ_AW-1:0] qptr_t;

  entry_t entries [OQ_DEPTH];
  qptr_t  wr_ptr;
  qptr_t  rd_ptr;
  logic   push;
  logic   pop;

  assign push = res.valid;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      occ    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == qptr_t'(OQ_DEPTH - 1)) ? '0 : wr_ptr + qptr_t'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == qptr_t'(OQ_DEPTH - 1)) ? '0 : rd_ptr + qptr_t'(1);
      end
      unique case ({push, pop})
        2'b10:   occ <= occ + (OQ_CW)'(1);
        2'b01:   occ <= occ - (OQ_CW)'(1);
        default: occ <= occ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= '{zone: res.smoothed_zone, sw: res.switched};
    end
  end

  assign out_valid     = (occ != '0);
  assign smoothed_zone = entries[rd_ptr].zone;
  assign switched      = entries[rd_ptr].sw;

endmodule

// ===== rtl/sliding_window_majority_smoother.sv =====
// ----------------------------------------------------------------------------
// sliding_window_majority_smoother
// Path: history and counts are read at the accept edge; the count stage then
//   updates the counts and pushes the result into the queue for the output.
// Throughput: one item per cycle while the result queue has room, set by the
//   count memory's read/write-back loop with forwarding; a three-entry result
//   queue absorbs output stalls.
// Reset: history and counts read as zero through valid bits (no clearing
//   pass); smoothed zone resets to 3, switch_threshold to 8.
// ----------------------------------------------------------------------------
module sliding_window_majority_smoother import swms_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  zone_t              zone,
  input  logic               confident,
  output logic               out_valid,
  input  logic               out_ready,
  output zone_t              smoothed_zone,
  output logic               switched,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  thr_t             switch_threshold;
  logic             take;
  logic             zone_ok;
  zone_t            old_zone;
  res_t             res;
  logic [OQ_CW-1:0] occ;
  logic             reg_sel;

  // configuration port
  assign pready  = 1'b1;
  assign reg_sel = (paddr[PADDR_W-1:2] == REG_SWITCH_THRESHOLD);

  always_ff @(posedge clk) begin
    if (rst) begin
      switch_threshold <= THR_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      switch_threshold <= pwdata[THR_W-1:0];
    end
  end

  assign prdata = reg_sel ? PDATA_W'(switch_threshold) : '0;

  // accept only with room for the result behind the one in flight
  assign in_ready = !rst &&
                    ((OQ_CW + 1)'(occ) + (OQ_CW + 1)'(res.valid) < (OQ_CW + 1)'(OQ_DEPTH));
  assign take     = in_valid && in_ready;
  assign zone_ok  = (zone <= zone_t'(NUM_ZONES));

  swms_ring u_ring (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .zone_ok  (zone_ok),
    .zone     (zone),
    .old_zone (old_zone)
  );

  swms_count u_count (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .zone_ok   (zone_ok),
    .zone      (zone),
    .confident (confident),
    .old_zone  (old_zone),
    .thr       (switch_threshold),
    .res       (res)
  );

  swms_outq u_outq (
    .clk           (clk),
    .rst           (rst),
    .res           (res),
    .occ           (occ),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .smoothed_zone (smoothed_zone),
    .switched      (switched)
  );

  // result queue never overflows
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (occ < OQ_CW'(OQ_DEPTH) || (out_valid && out_ready)))
    else $error("result queue overflow");

  // every accepted transfer reaches the count stage on the next cycle
  a_count_stage: assert property (@(posedge clk) disable iff (rst)
    take |=> res.valid)
    else $error("accepted item lost before count stage");

  // a switch always moves to a legal zone
  a_switch_legal: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.switched) |-> (res.smoothed_zone <= zone_t'(NUM_ZONES)))
    else $error("switched to an out-of-range zone");

endmodule

// ===== sim/tb_sliding_window_majority_smoother.sv =====
// ----------------------------------------------------------------------------
// tb_sliding_window_majority_smoother
// Self-checking bench for the zone smoother: a short table of directed items,
// then random bursts dominated by one zone under several thresholds. An
// in-bench model of the window counts predicts every result; both sides idle
// at random and the receiver holds off once long enough to stall the input.
// ----------------------------------------------------------------------------
module tb_sliding_window_majority_smoother;
  import swms_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 2000;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int NUM_PHASES = 8;
  localparam int LONG_HOLD = 80;

  localparam logic [PADDR_W-1:0] THRESH_ADDR = {REG_SWITCH_THRESHOLD, 2'b00};
  localparam logic [PADDR_W-1:0] SPARE_ADDR  = {~REG_SWITCH_THRESHOLD, 2'b00};

  typedef struct packed {
    zone_t zone;
    logic  sw;
  } smooth_out_t;

  typedef struct {
    zone_t zone;
    logic  conf;
    logic  typed;
    zone_t ezone;
    logic  esw;
  } zone_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  zone_t zone = '0;
  logic confident = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  zone_t smoothed_zone;
  logic switched;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  // typed-in expectation riding along with the current input transfer
  logic  row_typed = 1'b0;
  zone_t row_ezone = '0;
  logic  row_esw = 1'b0;

  // smoother model state
  zone_t zone_ring [0:WINDOW-1];
  cnt_t  zone_tally [0:NUM_ZONES];
  int    ring_pos;
  zone_t smooth_now;
  thr_t  thresh_now;

  smooth_out_t pending_zones[$];
  smooth_out_t mon_pred;
  smooth_out_t mon_want;
  int mismatches = 0;
  int in_count = 0;
  int quiet_cycles = 0;
  int rx_wait = 0;
  bit rx_hold_done = 1'b0;
  int unsigned rx_roll;

  zone_row_t dir_rows [25] = '{
    '{4'd15, 1'b1, 1'b1, 4'd3, 1'b0},  // zone out of range: ignored
    '{4'd9,  1'b1, 1'b1, 4'd3, 1'b0},
    '{4'd0,  1'b1, 1'b1, 4'd3, 1'b0},
    '{4'd0,  1'b0, 1'b1, 4'd3, 1'b0},
    '{4'd8,  1'b1, 1'b0, 4'd0, 1'b0},
    '{4'd8,  1'b1, 1'b0, 4'd0, 1'b0},
    '{4'd8,  1'b1, 1'b0, 4'd0, 1'b0},
    '{4'd8,  1'b1, 1'b0, 4'd0, 1'b0},
    '{4'd8,  1'b1, 1'b0, 4'd0, 1'b0},
    '{4'd8,  1'b1, 1'b0, 4'd0, 1'b0},
    '{4'd8,  1'b1, 1'b0, 4'd0, 1'b0},
    '{4'd8,  1'b1, 1'b0, 4'd0, 1'b0},
    '{4'd8,  1'b1, 1'b0, 4'd0, 1'b0},  // ninth 8 crosses the reset threshold
    '{4'd3,  1'b0, 1'b0, 4'd0, 1'b0},
    '{4'd3,  1'b0, 1'b0, 4'd0, 1'b0},
    '{4'd3,  1'b0, 1'b0, 4'd0, 1'b0},
    '{4'd3,  1'b0, 1'b0, 4'd0, 1'b0},
    '{4'd8,  1'b1, 1'b0, 4'd0, 1'b0},
    '{4'd8,  1'b1, 1'b0, 4'd0, 1'b0},
    '{4'd5,  1'b1, 1'b0, 4'd0, 1'b0},
    '{4'd1,  1'b1, 1'b0, 4'd0, 1'b0},
    '{4'd2,  1'b0, 1'b0, 4'd0, 1'b0},
    '{4'd4,  1'b1, 1'b0, 4'd0, 1'b0},
    '{4'd6,  1'b1, 1'b0, 4'd0, 1'b0},
    '{4'd7,  1'b1, 1'b0, 4'd0, 1'b0}
  };

  sliding_window_majority_smoother dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .zone(zone),
    .confident(confident),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .smoothed_zone(smoothed_zone),
    .switched(switched),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_smoother();
    foreach (zone_ring[i]) zone_ring[i] = '0;
    foreach (zone_tally[i]) zone_tally[i] = '0;
    ring_pos = 0;
    smooth_now = RESET_ZONE;
    thresh_now = THR_RESET;
  endfunction

  function automatic smooth_out_t advance_smoother(zone_t z, logic conf);
    smooth_out_t r;
    zone_t old;
    r.sw = 1'b0;
    if (int'(z) <= NUM_ZONES) begin
      old = zone_ring[ring_pos];
      if (zone_tally[old] != 0) zone_tally[old] = zone_tally[old] - 1'b1;
      if (int'(zone_tally[z]) < WINDOW) zone_tally[z] = zone_tally[z] + 1'b1;
      if (int'(zone_tally[z]) > int'(thresh_now) && z != smooth_now && conf) begin
        smooth_now = z;
        r.sw = 1'b1;
      end
      zone_ring[ring_pos] = z;
      ring_pos = (ring_pos + 1) % WINDOW;
    end
    r.zone = smooth_now;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int want, input int got);
    if (mismatches < 30)
      $display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $time);
    mismatches++;
  endtask

  // predict on each input transfer, check each output transfer
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        mon_pred = advance_smoother(zone, confident);
        if (row_typed) begin
          mon_pred.zone = row_ezone;
          mon_pred.sw = row_esw;
        end
        pending_zones.push_back(mon_pred);
        in_count <= in_count + 1;
      end
      if (out_valid && out_ready) begin
        if (pending_zones.size() == 0) begin
          flag_mismatch("result with nothing pending", -1, smoothed_zone);
        end else begin
          mon_want = pending_zones.pop_front();
          if (smoothed_zone !== mon_want.zone)
            flag_mismatch("smoothed_zone", mon_want.zone, smoothed_zone);
          if (switched !== mon_want.sw)
            flag_mismatch("switched", mon_want.sw, switched);
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  // receiver: random stalls, calm stretches, one long hold-off
  always @(posedge clk) begin
    if (rx_wait > 0) begin
      out_ready <= 1'b0;
      rx_wait <= rx_wait - 1;
    end else if (!rx_hold_done && in_count >= 300) begin
      out_ready <= 1'b0;
      rx_wait <= LONG_HOLD;
      rx_hold_done <= 1'b1;
    end else if ((in_count % 200) >= 150 && (in_count % 200) < 180) begin
      out_ready <= 1'b1;
    end else begin
      rx_roll = $urandom_range(0, 99);
      if (rx_roll < 70) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        rx_wait <= (rx_roll < 97) ? $urandom_range(0, 2) : $urandom_range(5, 25);
      end
    end
  end

  task automatic offer_zone(input zone_t z, input logic conf, input logic typed,
                            input zone_t ez, input logic esw);
    in_valid <= 1'b1;
    zone <= z;
    confident <= conf;
    row_typed <= typed;
    row_ezone <= ez;
    row_esw <= esw;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // drop valid and wait out every pending result; sample away from the edge
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_zones.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    @(posedge clk);
    if (addr[PADDR_W-1:2] == REG_SWITCH_THRESHOLD) thresh_now = data[THR_W-1:0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin
    int unsigned roll;
    int n;
    bit paused;
    zone_t dom;
    zone_t z;
    logic conf;
    clear_smoother();
    dom = zone_t'($urandom_range(0, NUM_ZONES));
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      offer_zone(dir_rows[i].zone, dir_rows[i].conf, dir_rows[i].typed,
                 dir_rows[i].ezone, dir_rows[i].esw);
    drain_results();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: write_reg(THRESH_ADDR, '0);
        1: begin
          write_reg(THRESH_ADDR, PDATA_W'(WINDOW));
          write_reg(SPARE_ADDR, PDATA_W'(2));  // no register there: ignored
        end
        2: write_reg(THRESH_ADDR, 32'hFFFF_FFE3);  // upper bits dropped
        3: write_reg(THRESH_ADDR, 32'hFFFF_FFFF);
        default: begin
          write_reg(THRESH_ADDR, $urandom_range(1, 15));
          if ($urandom_range(0, 1) == 1) write_reg(SPARE_ADDR, $urandom);
        end
      endcase

      n = 0;
      paused = 1'b0;
      while (n < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 99) < 3) dom = zone_t'($urandom_range(0, NUM_ZONES));
        roll = $urandom_range(0, 99);
        if (roll < 5) z = zone_t'($urandom_range(NUM_ZONES + 1, 15));
        else if (roll < 75) z = dom;
        else z = zone_t'($urandom_range(0, NUM_ZONES));
        conf = ($urandom_range(0, 99) < 85);
        offer_zone(z, conf, 1'b0, '0, 1'b0);
        if (int'(z) <= NUM_ZONES) n++;
        if (phase == 5 && n >= 50 && !paused) begin
          paused = 1'b1;
          drain_results();
        end else if (n >= 20) begin
          roll = $urandom_range(0, 99);
          if (roll >= 95) idle_sender($urandom_range(8, 30));
          else if (roll >= 65) idle_sender($urandom_range(1, 3));
        end
      end
      drain_results();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/swms_pkg.sv
rtl/swms_ram.sv
rtl/swms_ring.sv
rtl/swms_count.sv
rtl/swms_outq.sv
rtl/sliding_window_majority_smoother.sv
sim/tb_sliding_window_majority_smoother.sv
